[src/gbn_pkg.sv]
`default_nettype none

package gbn_pkg;

  // Store sizing: the store holds at most MSG_LIMIT messages.
  localparam int MSG_STORE_DEPTH = 1024;
  localparam int MAX_WINDOW      = 64;
  localparam int MSG_LIMIT       = 1000;
  localparam int STORE_LIMIT     = (MSG_LIMIT < MSG_STORE_DEPTH) ? MSG_LIMIT : MSG_STORE_DEPTH;

  // Counter, address and word widths.
  localparam int CNT_W   = $clog2(STORE_LIMIT + 1);
  localparam int ADDR_W  = $clog2(MSG_STORE_DEPTH);
  localparam int WIN_W   = 7;
  localparam int SEQ_W   = 10;
  localparam int BSUM_W  = 13;
  localparam int MSG_W   = 160;
  localparam int ENTRY_W = MSG_W + BSUM_W;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [WIN_W-1:0]   win_t;
  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [BSUM_W-1:0]  bsum_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Request codes.
  localparam logic [1:0] REQ_NEW     = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // Timer action codes.
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DECODE,
    ST_READ,
    ST_LOAD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[src/go_back_n_sender.sv]
`default_nettype none

// Go-Back-N sender with a 1024-entry message store in a single-port-write,
// registered-read memory.
// Input channel (in_valid/in_stall): one request per transfer, a new message,
// an arriving ACK or a timer expiry. Output channel (out_valid/out_stall):
// one row per transfer; every request yields one or more rows and the final
// one has last set. Timer action and the drop flag appear on the first row.
// Configuration channel (cfg_valid/cfg_ready): writes window_size, always
// ready; it is meant to be written while the block is idle.
// With nothing to send, a request passes through ST_SUM and ST_DECODE before
// its single row is valid; a send run passes through ST_SUM, ST_DECODE, ST_READ
// and ST_LOAD before its first data packet. Each data packet takes a memory
// read, a load of the output register and its transfer, and the next packet's
// read starts only after that transfer, so a request holds the input until
// its last row is taken; a timeout resends at most a full window of 64 packets.
// The memory read per packet sets the packet rate.
// One request is handled at a time: in_stall is high from the transfer until
// the last row has been taken. While out_stall is high the current row holds.
// Reset (rst, synchronous) empties the store, closes the window, stops the
// timer and sets window_size to 8. No clearing pass is needed.
module go_back_n_sender (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] pkt_seq,
  input  wire logic signed [31:0] pkt_ack,
  input  wire logic signed [31:0] pkt_checksum,
  input  wire logic [63:0]        payload_a,
  input  wire logic [63:0]        payload_b,
  input  wire logic [31:0]        payload_c,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    send_valid,
  output logic [9:0]              out_seq,
  output logic signed [31:0]      out_checksum,
  output logic [63:0]             out_payload_a,
  output logic [63:0]             out_payload_b,
  output logic [31:0]             out_payload_c,
  output logic [1:0]              timer_action,
  output logic                    dropped,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         cfg_data
);

  // Sum of the twenty payload bytes.
  function automatic gbn_pkg::bsum_t byte_sum(input logic [63:0] a, input logic [63:0] b,
                                              input logic [31:0] c);
    gbn_pkg::bsum_t s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + gbn_pkg::bsum_t'(a[8*i +: 8]) + gbn_pkg::bsum_t'(b[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      s = s + gbn_pkg::bsum_t'(c[8*i +: 8]);
    end
    return s;
  endfunction

  // Control state.
  gbn_pkg::state_t state, state_next;
  gbn_pkg::cnt_t   stored_count, stored_count_next;
  gbn_pkg::cnt_t   window_base, window_base_next;
  gbn_pkg::cnt_t   next_to_send, next_to_send_next;
  gbn_pkg::cnt_t   ptr, ptr_next;
  gbn_pkg::win_t   window_size;
  logic            timer_running, timer_running_next;
  logic            resend, resend_next;
  logic            first, first_next;
  logic [1:0]      act, act_next;
  logic            out_valid_next;

  // Captured request and its sums.
  logic [1:0]      req_r;
  logic [31:0]     seq_r, ack_r, cks_r, hsum;
  logic [63:0]     pa_r, pb_r;
  logic [31:0]     pc_r;
  gbn_pkg::bsum_t  bsum;
  logic            more;

  // Output row next values.
  logic            send_valid_next, dropped_next, last_next;
  logic [9:0]      out_seq_next;
  logic [31:0]     out_checksum_next;
  logic [63:0]     out_payload_a_next, out_payload_b_next;
  logic [31:0]     out_payload_c_next;
  logic [1:0]      timer_action_next;

  // Message store: payload and its precomputed byte sum per entry.
  gbn_pkg::entry_t store_mem [gbn_pkg::MSG_STORE_DEPTH];
  gbn_pkg::entry_t rd_data;
  logic            mem_we, mem_re;
  gbn_pkg::addr_t  mem_wa, mem_ra;
  gbn_pkg::entry_t mem_wd;

  gbn_pkg::win_t   eff_win;
  gbn_pkg::cnt_t   ptr_inc;
  gbn_pkg::cnt_t   ack_inc;
  logic            more_calc;

  assign in_stall  = (state != gbn_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign eff_win   = (window_size > gbn_pkg::win_t'(gbn_pkg::MAX_WINDOW)) ?
                     gbn_pkg::win_t'(gbn_pkg::MAX_WINDOW) : window_size;
  assign ptr_inc   = ptr + gbn_pkg::cnt_t'(1);
  assign ack_inc   = gbn_pkg::cnt_t'(ack_r) + gbn_pkg::cnt_t'(1);

  // Whether another packet follows the one at ptr.
  assign more_calc = resend ? (ptr_inc < next_to_send) :
                     (((ptr_inc - window_base) < gbn_pkg::cnt_t'(eff_win)) &&
                      (ptr_inc < stored_count));

  // Memory port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= store_mem[mem_ra];
    end
  end

  // Next state, bookkeeping and the output row.
  always_comb begin
    logic          sends;
    logic          stop;
    logic          ack_ok;
    gbn_pkg::cnt_t cnt_inc;
    state_next         = state;
    stored_count_next  = stored_count;
    window_base_next   = window_base;
    next_to_send_next  = next_to_send;
    ptr_next           = ptr;
    timer_running_next = timer_running;
    resend_next        = resend;
    first_next         = first;
    act_next           = act;
    out_valid_next     = out_valid;
    send_valid_next    = send_valid;
    out_seq_next       = out_seq;
    out_checksum_next  = out_checksum;
    out_payload_a_next = out_payload_a;
    out_payload_b_next = out_payload_b;
    out_payload_c_next = out_payload_c;
    timer_action_next  = timer_action;
    dropped_next       = dropped;
    last_next          = last;
    mem_we             = 1'b0;
    mem_wa             = gbn_pkg::addr_t'(stored_count);
    mem_wd             = {bsum, pc_r, pb_r, pa_r};
    mem_re             = 1'b0;
    mem_ra             = gbn_pkg::addr_t'(ptr);
    sends              = 1'b0;
    stop               = 1'b0;
    cnt_inc            = stored_count + gbn_pkg::cnt_t'(1);
    ack_ok             = ((hsum + 32'(bsum)) == cks_r) &&
                         (ack_r >= 32'(window_base)) && (ack_r < 32'(next_to_send));

    case (state)
      gbn_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = gbn_pkg::ST_SUM;
        end
      end

      gbn_pkg::ST_SUM: begin
        state_next = gbn_pkg::ST_DECODE;
      end

      gbn_pkg::ST_DECODE: begin
        // Default to a single empty row; a send run overrides it.
        first_next         = 1'b1;
        resend_next        = 1'b0;
        ptr_next           = next_to_send;
        act_next           = gbn_pkg::TMR_NONE;
        send_valid_next    = 1'b0;
        out_seq_next       = '0;
        out_checksum_next  = '0;
        out_payload_a_next = '0;
        out_payload_b_next = '0;
        out_payload_c_next = '0;
        timer_action_next  = gbn_pkg::TMR_NONE;
        dropped_next       = 1'b0;
        last_next          = 1'b1;
        case (req_r)
          gbn_pkg::REQ_NEW: begin
            if (stored_count >= gbn_pkg::cnt_t'(gbn_pkg::STORE_LIMIT)) begin
              dropped_next = 1'b1;
            end else begin
              mem_we            = 1'b1;
              stored_count_next = cnt_inc;
              sends = ((next_to_send - window_base) < gbn_pkg::cnt_t'(eff_win)) &&
                      (next_to_send < cnt_inc);
              if (sends && !timer_running) begin
                act_next           = gbn_pkg::TMR_START;
                timer_running_next = 1'b1;
              end
            end
          end
          gbn_pkg::REQ_ACK: begin
            if (ack_ok) begin
              window_base_next = ack_inc;
              stop  = (ack_inc == next_to_send);
              sends = ((next_to_send - ack_inc) < gbn_pkg::cnt_t'(eff_win)) &&
                      (next_to_send < stored_count);
              act_next           = (stop && !sends) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
              timer_running_next = !stop || sends;
            end
          end
          gbn_pkg::REQ_TIMEOUT: begin
            act_next           = gbn_pkg::TMR_START;
            timer_running_next = 1'b1;
            resend_next        = 1'b1;
            ptr_next           = window_base;
            sends              = (window_base < next_to_send);
          end
          default: begin
          end
        endcase
        timer_action_next = act_next;
        if (sends) begin
          state_next = gbn_pkg::ST_READ;
        end else begin
          out_valid_next = 1'b1;
          state_next     = gbn_pkg::ST_OUT;
        end
      end

      gbn_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = gbn_pkg::ST_LOAD;
      end

      gbn_pkg::ST_LOAD: begin
        // Build the data packet from the entry read last cycle.
        out_valid_next     = 1'b1;
        send_valid_next    = 1'b1;
        out_seq_next       = gbn_pkg::seq_t'(ptr);
        out_checksum_next  = 32'(ptr) + 32'(rd_data[gbn_pkg::MSG_W +: gbn_pkg::BSUM_W]);
        out_payload_a_next = rd_data[63:0];
        out_payload_b_next = rd_data[127:64];
        out_payload_c_next = rd_data[159:128];
        timer_action_next  = first ? act : gbn_pkg::TMR_NONE;
        dropped_next       = 1'b0;
        last_next          = !more;
        first_next         = 1'b0;
        ptr_next           = ptr_inc;
        if (!resend) begin
          next_to_send_next = ptr_inc;
        end
        state_next = gbn_pkg::ST_OUT;
      end

      gbn_pkg::ST_OUT: begin
        if (!out_stall) begin
          out_valid_next = 1'b0;
          state_next     = last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_READ;
        end
      end

      default: begin
        state_next = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gbn_pkg::ST_IDLE;
      stored_count  <= '0;
      window_base   <= '0;
      next_to_send  <= '0;
      ptr           <= '0;
      timer_running <= 1'b0;
      resend        <= 1'b0;
      first         <= 1'b0;
      act           <= gbn_pkg::TMR_NONE;
      out_valid     <= 1'b0;
      window_size   <= gbn_pkg::win_t'(8);
    end else begin
      state         <= state_next;
      stored_count  <= stored_count_next;
      window_base   <= window_base_next;
      next_to_send  <= next_to_send_next;
      ptr           <= ptr_next;
      timer_running <= timer_running_next;
      resend        <= resend_next;
      first         <= first_next;
      act           <= act_next;
      out_valid     <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
    end
  end

  // Payload registers: captured request, sums and the output row.
  always_ff @(posedge clk) begin
    if (state == gbn_pkg::ST_IDLE && in_valid) begin
      req_r <= req_type;
      seq_r <= pkt_seq;
      ack_r <= pkt_ack;
      cks_r <= pkt_checksum;
      pa_r  <= payload_a;
      pb_r  <= payload_b;
      pc_r  <= payload_c;
    end
    if (state == gbn_pkg::ST_SUM) begin
      bsum <= byte_sum(pa_r, pb_r, pc_r);
      hsum <= seq_r + ack_r;
    end
    if (state == gbn_pkg::ST_READ) begin
      more <= more_calc;
    end
    send_valid    <= send_valid_next;
    out_seq       <= out_seq_next;
    out_checksum  <= out_checksum_next;
    out_payload_a <= out_payload_a_next;
    out_payload_b <= out_payload_b_next;
    out_payload_c <= out_payload_c_next;
    timer_action  <= timer_action_next;
    dropped       <= dropped_next;
    last          <= last_next;
  end

  // The window never runs past the stored messages.
  assert property (@(posedge clk) disable iff (rst)
    (window_base <= next_to_send) && (next_to_send <= stored_count))
    else $error("window bounds out of order");

  // At most a full window is in flight.
  assert property (@(posedge clk) disable iff (rst)
    (next_to_send - window_base) <= gbn_pkg::cnt_t'(gbn_pkg::MAX_WINDOW))
    else $error("in-flight count exceeds the window limit");

  // A data packet on the output implies the timer is running.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_valid) |-> timer_running)
    else $error("packet sent with the timer stopped");

  // No result row is shown in the cycle after a request transfer.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown before the request was decoded");

  // The entry loaded for a packet lies within the stored messages.
  assert property (@(posedge clk) disable iff (rst)
    (state == gbn_pkg::ST_LOAD) |-> (ptr < next_to_send || (!resend && ptr < stored_count)))
    else $error("packet read beyond the stored messages");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] cks;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] c;
  } request_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] c;
  } msg_t;

  typedef struct packed {
    logic        sent;
    logic [9:0]  seq;
    logic [31:0] cks;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] c;
    logic [1:0]  timer;
    logic        drop;
    logic        last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = gbn_pkg::REQ_NEW;
  logic signed [31:0] pkt_seq = '0;
  logic signed [31:0] pkt_ack = '0;
  logic signed [31:0] pkt_checksum = '0;
  logic [63:0]        payload_a = '0;
  logic [63:0]        payload_b = '0;
  logic [31:0]        payload_c = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               send_valid;
  logic [9:0]         out_seq;
  logic signed [31:0] out_checksum;
  logic [63:0]        out_payload_a;
  logic [63:0]        out_payload_b;
  logic [31:0]        out_payload_c;
  logic [1:0]         timer_action;
  logic               dropped;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_data = '0;

  go_back_n_sender DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .pkt_seq      (pkt_seq),
    .pkt_ack      (pkt_ack),
    .pkt_checksum (pkt_checksum),
    .payload_a    (payload_a),
    .payload_b    (payload_b),
    .payload_c    (payload_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .send_valid   (send_valid),
    .out_seq      (out_seq),
    .out_checksum (out_checksum),
    .out_payload_a(out_payload_a),
    .out_payload_b(out_payload_b),
    .out_payload_c(out_payload_c),
    .timer_action (timer_action),
    .dropped      (dropped),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sender state as the block should hold it.
  msg_t        msg_mem [gbn_pkg::MSG_STORE_DEPTH];
  logic [31:0] held_count = '0;
  logic [31:0] win_base = '0;
  logic [31:0] win_next = '0;
  logic        timer_on = 1'b0;
  logic [6:0]  win_limit = 7'd8;

  request_t req_backlog[$];
  row_t     due_rows[$];
  row_t     batch[$];
  logic [1:0] batch_timer;
  logic       batch_drop;

  request_t held_req;
  int issued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int rows_checked = 0;
  int n_drop = 0;
  int n_ack_taken = 0;
  int n_ignored = 0;
  int window_writes = 0;
  int cycle_count = 0;
  bit idle_off = 1'b0;

  // Wrapping 32-bit sum of the twenty payload bytes.
  function automatic logic [31:0] byte_total(logic [63:0] a, logic [63:0] b, logic [31:0] c);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) s += a[8*i +: 8] + b[8*i +: 8];
    for (int i = 0; i < 4; i++) s += c[8*i +: 8];
    return s;
  endfunction

  function automatic logic [31:0] open_window();
    return (win_limit > gbn_pkg::MAX_WINDOW) ? gbn_pkg::MAX_WINDOW : win_limit;
  endfunction

  // A data packet rebuilt from the store for sequence number s.
  function automatic row_t packet_row(logic [31:0] s);
    row_t  r;
    msg_t  m;
    m = msg_mem[s % gbn_pkg::MSG_STORE_DEPTH];
    r = '0;
    r.sent = 1'b1;
    r.seq = s[9:0];
    r.cks = s + byte_total(m.a, m.b, m.c);
    r.a = m.a;
    r.b = m.b;
    r.c = m.c;
    return r;
  endfunction

  // Send stored messages while the window has room.
  task automatic send_fresh();
    while (batch.size() < gbn_pkg::MAX_WINDOW && win_next - win_base < open_window()
           && win_next < held_count) begin
      batch = {batch, packet_row(win_next)};
      if (!timer_on) begin
        timer_on = 1'b1;
        batch_timer = batch_timer | gbn_pkg::TMR_START;
      end
      win_next++;
    end
  endtask

  // Updates the sender state for one request and queues the rows it causes.
  task automatic work_out_rows(input request_t r);
    logic [31:0] sum;
    logic [31:0] s;
    batch.delete();
    batch_timer = gbn_pkg::TMR_NONE;
    batch_drop = 1'b0;
    case (r.kind)
      gbn_pkg::REQ_NEW: begin
        if (held_count >= gbn_pkg::STORE_LIMIT) begin
          batch_drop = 1'b1;
          n_drop++;
        end else begin
          msg_mem[held_count % gbn_pkg::MSG_STORE_DEPTH] = '{r.a, r.b, r.c};
          held_count++;
          send_fresh();
        end
      end
      gbn_pkg::REQ_ACK: begin
        sum = r.seq + r.ack + byte_total(r.a, r.b, r.c);
        if (sum == r.cks && r.ack >= win_base && r.ack < win_next) begin
          n_ack_taken++;
          win_base = r.ack + 1;
          if (win_base == win_next) begin
            timer_on = 1'b0;
            batch_timer = gbn_pkg::TMR_STOP;
          end else begin
            timer_on = 1'b1;
            batch_timer = gbn_pkg::TMR_RESTART;
          end
          send_fresh();
        end else begin
          n_ignored++;
        end
      end
      gbn_pkg::REQ_TIMEOUT: begin
        timer_on = 1'b1;
        batch_timer = gbn_pkg::TMR_START;
        for (s = win_base; s < win_next && batch.size() < gbn_pkg::MAX_WINDOW; s++)
          batch = {batch, packet_row(s)};
      end
      default: begin
        n_ignored++;
      end
    endcase
    if (batch.size() == 0) batch = {batch, row_t'('0)};
    batch[0].timer = batch_timer;
    batch[0].drop = batch_drop;
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_rows = {due_rows, batch[i]};
  endtask

  // Request driver: takes items from the backlog, with bursts of idle cycles.
  int send_rest = 0;
  bit send_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        work_out_rows(held_req);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        if (send_rest > 0) begin
          send_rest--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          held_req = req_backlog.pop_front();
          req_type <= held_req.kind;
          pkt_seq <= held_req.seq;
          pkt_ack <= held_req.ack;
          pkt_checksum <= held_req.cks;
          payload_a <= held_req.a;
          payload_b <= held_req.b;
          payload_c <= held_req.c;
          in_valid <= 1'b1;
          if (!idle_off && !send_calm && $urandom_range(0, 3) == 0)
            send_rest = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Packet monitor: checks every row transfer against the oldest row due.
  int take_rest = 0;
  bit take_calm = 1'b0;
  row_t want_row;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 30)
            $display("%0t ns: row expected none, actual seq %0d last %b", $time, out_seq, last);
        end else begin
          want_row = due_rows.pop_front();
          rows_checked++;
          check_field("send_valid", want_row.sent, send_valid);
          check_field("out_seq", want_row.seq, out_seq);
          check_field("out_checksum", want_row.cks, $unsigned(out_checksum));
          check_field("out_payload_a", want_row.a, out_payload_a);
          check_field("out_payload_b", want_row.b, out_payload_b);
          check_field("out_payload_c", want_row.c, out_payload_c);
          check_field("timer_action", want_row.timer, timer_action);
          check_field("dropped", want_row.drop, dropped);
          check_field("last", want_row.last, last);
        end
      end
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      if (take_rest > 0) begin
        take_rest--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!idle_off && !take_calm && $urandom_range(0, 7) == 0)
          take_rest = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d rows outstanding.", cycle_count,
               due_rows.size());
      $display("go_back_n_sender: mismatch");
      $finish;
    end
  end

  // Hands one request to the driver and waits until its transfer, so that the
  // sender state seen by the next request is current.
  task automatic issue(input request_t r);
    req_backlog = {req_backlog, r};
    issued_count++;
    while (accepted_count != issued_count) @(negedge clk);
  endtask

  function automatic request_t plain_req(input logic [1:0] kind);
    request_t r;
    r = '0;
    r.kind = kind;
    r.seq = $urandom;
    r.ack = $urandom;
    r.cks = $urandom;
    r.a = {$urandom, $urandom};
    r.b = {$urandom, $urandom};
    r.c = $urandom;
    return r;
  endfunction

  function automatic request_t message_req(input logic [63:0] a, input logic [63:0] b,
                                           input logic [31:0] c);
    request_t r;
    r = plain_req(gbn_pkg::REQ_NEW);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  function automatic request_t random_message();
    return message_req({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endfunction

  // ACK packet with a correct checksum, or one bit of it flipped when spoilt.
  function automatic request_t ack_req(input logic [31:0] seq, input logic [31:0] ackno,
                                       input bit spoil);
    request_t r;
    r = plain_req(gbn_pkg::REQ_ACK);
    r.seq = seq;
    r.ack = ackno;
    r.cks = seq + ackno + byte_total(r.a, r.b, r.c);
    if (spoil) r.cks = r.cks ^ (32'd1 << $urandom_range(0, 31));
    return r;
  endfunction

  // An ACK that the sender must ignore.
  function automatic request_t broken_ack();
    case ($urandom_range(0, 4))
      0:       return ack_req($urandom, win_base, 1'b1);
      1:       return ack_req($urandom, win_next, 1'b0);
      2:       return ack_req($urandom, win_base - 1, 1'b0);
      3:       return ack_req($urandom, {1'b1, 31'($urandom)}, 1'b0);
      default: return plain_req(gbn_pkg::REQ_ACK);
    endcase
  endfunction

  // Mostly well-formed traffic: messages, in-window ACKs and timeouts,
  // with some broken ACKs and unused request codes mixed in.
  task automatic random_phase(input int target);
    int done;
    int pick;
    logic [31:0] flight;
    done = 0;
    while (done < target) begin
      flight = win_next - win_base;
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick < 75 && flight == 0)) begin
        issue(random_message());
        done++;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) == 0)
          issue(ack_req($urandom, win_next - 1, 1'b0));
        else
          issue(ack_req($urandom, win_base + $urandom_range(0, flight - 1), 1'b0));
        done++;
      end else if (pick < 85) begin
        issue(plain_req(gbn_pkg::REQ_TIMEOUT));
        done++;
      end else if (pick < 97) begin
        issue(broken_ack());
      end else begin
        issue(plain_req(REQ_SPARE));
      end
    end
  endtask

  // Writes window_size once every row due has been taken.
  task automatic write_window(input logic [6:0] w);
    while (due_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_limit = w;
    window_writes++;
    @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset window of eight.
    issue(plain_req(gbn_pkg::REQ_TIMEOUT));
    issue(plain_req(REQ_SPARE));
    issue(ack_req(32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
    issue(message_req('0, '0, '0));
    issue(message_req('1, '1, '1));
    repeat (7) issue(random_message());
    issue(ack_req(32'h7FFF_FFFF, win_base, 1'b0));
    issue(ack_req($urandom, win_base, 1'b1));
    issue(ack_req($urandom, win_next, 1'b0));
    issue(plain_req(gbn_pkg::REQ_TIMEOUT));
    issue(ack_req(32'h0, win_next - 1, 1'b0));
    issue(random_message());
    issue(ack_req(32'h8000_0000, win_base, 1'b0));
    issue(plain_req(gbn_pkg::REQ_TIMEOUT));

    // A closed window sends no new messages, however much is stored.
    write_window(7'd0);
    random_phase(15);
    write_window(7'd64);
    random_phase(50);
    // Shrink well below the number in flight.
    write_window(7'd3);
    random_phase(45);
    write_window(7'd1);
    random_phase(30);
    write_window(7'($urandom_range(2, 63)));
    random_phase(50);

    // Window above the maximum, full-size bursts, no idling.
    write_window(7'd127);
    idle_off = 1'b1;
    issue(ack_req($urandom, win_next - 1, 1'b0));
    issue(plain_req(gbn_pkg::REQ_TIMEOUT));
    random_phase(25);

    while (due_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d requests: %0d messages stored, %0d dropped, %0d ACKs taken, %0d ignored.",
             accepted_count, held_count, n_drop, n_ack_taken, n_ignored);
    $display("Checked %0d packet rows over %0d window settings.", rows_checked,
             window_writes + 1);
    if (mismatches == 0 && due_rows.size() == 0) begin
      $display("go_back_n_sender: match");
    end else begin
      $display("go_back_n_sender: mismatch");
    end
    $finish;
  end

endmodule
